### src/sha1_pkg.sv
// Shared types and constants for the SHA-1 stream hasher.
`default_nettype none
package sha1_pkg;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_FINISH = 1'b1;
    localparam logic ST_OK = 1'b0;
    localparam logic ST_TOO_LONG = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAD_ZERO,
        S_LOAD_RD,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_EMIT,
        S_ERR
    } t_state;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction
endpackage
`default_nettype wire

### src/sha1_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module sha1_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### src/sha1_stream_hasher_top.sv
// Top level of the SHA-1 stream hasher: block buffer, schedule, rounds and output.
// A data beat is accepted only in idle; the 64th byte of a block starts a compression
// (one read-issue step, 64 byte loads, 80 rounds, one add), during which no bytes are taken;
// throughput is set by the byte-wide load and the single round unit.
// A finish pads one byte per cycle up to byte 63, runs one or two compressions, then emits
// five beats (one on too-long). Sync active-low reset: initial hash, counts cleared.
`default_nettype none
module sha1_stream_hasher_top
    import sha1_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  wire logic        s_axis_tuser,  // [0] op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // [2:0] word_index, [34:3] digest_word
    output logic             m_axis_tuser,  // [0] status
    output logic             m_axis_tlast   // last
);
    t_state r_state, n_state;
    logic [5:0]  r_fill;
    logic        r_full;
    logic [63:0] r_len;
    logic        r_too_long;
    logic        r_final;
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [16];
    logic [6:0]  r_rnd;
    logic [5:0]  r_ld;
    logic [2:0]  r_oidx;
    logic [23:0] r_part;

    logic        we;
    logic [5:0]  waddr, raddr;
    logic [7:0]  wdata, rdata;
    logic        acc;

    sha1_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign acc = s_axis_tvalid && s_axis_tready;

    // load phase: r_ld counts bytes returned by the memory (registered read)
    logic [31:0] wnew, f, k, t;
    logic [1:0]  ph;
    always_comb begin
        wnew = rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 1);
        ph = (r_rnd < 7'd20) ? 2'd0 : (r_rnd < 7'd40) ? 2'd1 : (r_rnd < 7'd60) ? 2'd2 : 2'd3;
        unique case (ph)
            2'd0: begin f = (r_b & r_c) | (~r_b & r_d); k = K0; end
            2'd1: begin f = r_b ^ r_c ^ r_d; k = K1; end
            2'd2: begin f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d); k = K2; end
            default: begin f = r_b ^ r_c ^ r_d; k = K3; end
        endcase
        t = rotl(r_a, 5) + f + r_e + r_w[0] + k;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc && s_axis_tuser == OP_FINISH) begin
                    if (r_too_long) n_state = S_ERR;
                    else if (r_fill == 6'd63) n_state = S_LOAD_RD;
                    else n_state = S_PAD_ZERO;
                end else if (acc && !r_too_long && r_fill == 6'd63) begin
                    n_state = S_LOAD_RD;
                end
            end
            S_PAD_ZERO: begin
                if (r_fill == 6'd63) begin
                    n_state = S_LOAD_RD;
                end
            end
            S_LOAD_RD: n_state = S_LOAD;
            S_LOAD:    if (r_ld == 6'd63) n_state = S_ROUND;
            S_ROUND:   if (r_rnd == 7'd79) n_state = S_ADD;
            S_ADD: begin
                if (!r_final) n_state = S_IDLE;
                else if (r_full) n_state = S_PAD_ZERO;
                else n_state = S_EMIT;
            end
            S_EMIT: if (m_axis_tready && r_oidx == 3'd4) n_state = S_IDLE;
            S_ERR:  if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory write port and read address
    logic [2:0] lsel;
    always_comb begin
        we = 1'b0;
        waddr = r_fill;
        wdata = s_axis_tdata;
        raddr = '0;
        lsel = 3'd7 - r_fill[2:0];
        if (r_state == S_IDLE) begin
            we = acc && !r_too_long;
            if (s_axis_tuser == OP_FINISH) wdata = PAD_BYTE;
        end else if (r_state == S_PAD_ZERO) begin
            we = 1'b1;
            wdata = (r_fill >= LEN_POS && !r_full) ? r_len[lsel*8 +: 8] : 8'h00;
        end
        if (r_state == S_LOAD) begin
            raddr = r_ld + 6'd1;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_EMIT) || (r_state == S_ERR);
    assign m_axis_tuser  = (r_state == S_ERR) ? ST_TOO_LONG : ST_OK;
    assign m_axis_tlast  = (r_state == S_ERR) || (r_oidx == 3'd4);
    assign m_axis_tdata  = {5'd0, (r_state == S_ERR) ? 32'd0 : r_h[r_oidx],
                            (r_state == S_ERR) ? 3'd0 : r_oidx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0;
            r_full <= 1'b0;
            r_len <= '0;
            r_too_long <= 1'b0;
            r_final <= 1'b0;
            r_oidx <= '0;
            r_ld <= '0;
            r_rnd <= '0;
            r_part <= '0;
            r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2; r_h[3] <= H3; r_h[4] <= H4;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (acc && s_axis_tuser == OP_FINISH) begin
                        r_final <= 1'b1;
                        r_full <= (r_fill > 6'd55);
                        r_fill <= r_fill + 6'd1;
                    end else if (acc && !r_too_long) begin
                        r_fill <= r_fill + 6'd1;
                        r_len <= r_len + 64'd8;
                        if (r_len == 64'hFFFF_FFFF_FFFF_FFF8) r_too_long <= 1'b1;
                    end
                    r_ld <= '0;
                    r_part <= '0;
                end
                S_PAD_ZERO: r_fill <= r_fill + 6'd1;
                S_LOAD_RD: begin
                    r_ld <= '0;
                    r_part <= '0;
                    r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                    r_d <= r_h[3]; r_e <= r_h[4];
                    r_rnd <= '0;
                end
                S_LOAD: begin
                    if (r_ld[1:0] == 2'd3) begin
                        for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                        r_w[15] <= {r_part, rdata};
                    end
                    r_part <= {r_part[15:0], rdata};
                    r_ld <= r_ld + 6'd1;
                end
                S_ROUND: begin
                    r_e <= r_d; r_d <= r_c; r_c <= rotl(r_b, 30); r_b <= r_a; r_a <= t;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= wnew;
                    r_rnd <= r_rnd + 7'd1;
                end
                S_ADD: begin
                    r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    r_fill <= '0;
                    r_full <= 1'b0;
                    r_oidx <= '0;
                end
                S_EMIT: begin
                    if (m_axis_tready) begin
                        if (r_oidx == 3'd4) begin
                            r_fill <= '0; r_len <= '0; r_too_long <= 1'b0;
                            r_final <= 1'b0; r_oidx <= '0;
                            r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2;
                            r_h[3] <= H3; r_h[4] <= H4;
                        end else begin
                            r_oidx <= r_oidx + 3'd1;
                        end
                    end
                end
                S_ERR: begin
                    if (m_axis_tready) begin
                        r_fill <= '0; r_len <= '0; r_too_long <= 1'b0;
                        r_final <= 1'b0; r_full <= 1'b0; r_oidx <= '0;
                        r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2;
                        r_h[3] <= H3; r_h[4] <= H4;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
